### src/kmp_pkg.sv
// Shared types and constants for the streaming KMP byte matcher.
`timescale 1ns / 1ps
`default_nettype none
package kmp_pkg;

    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 32;
    localparam int COUNT_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic              shift;     // text beat: partial-match flags advance
        logic              flush;     // drop all partial matches
        logic              load;      // append beat: tail marker moves
        logic              drop;      // pattern cleared: tail marker goes away
        logic [CHAR_W-1:0] data_char; // byte on this beat
    } cell_ctrl_t;

endpackage
`default_nettype wire

### src/kmp_cell.sv
// One matcher cell: a pattern byte, its partial-match flag and the tail marker.
`timescale 1ns / 1ps
`default_nettype none
module kmp_cell
    import kmp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       wr_en,
    input  wire logic       prev_hit,
    output logic            hit,
    output logic            tail_hit
);

    logic [CHAR_W-1:0] pat_reg;
    logic              hit_reg;
    logic              hit_next;
    logic              last_reg;

    // Pattern bytes 0..i end at this text byte.
    assign hit_next = prev_hit && (pat_reg == ctrl.data_char);
    assign hit      = hit_reg;
    assign tail_hit = hit_next && last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_reg <= ctrl.data_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.flush)
            begin
                hit_reg <= 1'b0;
            end
            else if (ctrl.shift)
            begin
                hit_reg <= hit_next;
            end

            if (ctrl.drop)
            begin
                last_reg <= 1'b0;
            end
            else if (ctrl.load)
            begin
                last_reg <= wr_en;
            end
        end
    end

endmodule
`default_nettype wire

### src/kmp_stream_matcher.sv
// Top level of the streaming KMP byte matcher: sequencer, cell row, result register.
//
// Usage:
//   Item channel (item_valid / item_stall, fields func and data_char) carries
//   one command per beat: clear pattern, append pattern byte, text byte or
//   restart text. Result channel (result_valid / result_stall) returns exactly
//   one beat per item: match, match_start, error and pattern_count.
//   Matching runs in a row of PATTERN_MAX cells. Cell i holds pattern byte i
//   and a flag telling that pattern bytes 0..i end at the previous text byte;
//   on a text beat every flag moves one cell up, gated by that cell's byte
//   compare. The cell holding the last pattern byte reports a full occurrence,
//   so overlapping occurrences come out with no fallback walk: the same
//   answers as KMP in a fixed single step per byte.
//   The result of an item is registered and is on the result port in the
//   cycle after its beat. Throughput: one item per cycle while results are
//   taken; the item side stalls only while a result waits under result_stall,
//   and a new item is accepted in the same cycle that the waiting result leaves.
//   Reset: pattern empty, no partial matches, text position zero, no result
//   pending. Pattern bytes themselves are not reset; stale bytes past the
//   pattern may still be compared, but only the tail cell reports a match.
`timescale 1ns / 1ps
`default_nettype none
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [CHAR_W-1:0]  data_char,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic                    match,
    output logic [POS_W-1:0]        match_start,
    output logic                    error,
    output logic [COUNT_W-1:0]      pattern_count
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int EXT_W = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

    // Pattern length and text position of the next text byte.
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    // Result register.
    logic               result_valid_reg;
    logic               result_valid_next;
    logic               match_reg;
    logic [POS_W-1:0]   start_reg;
    logic               error_reg;
    logic [COUNT_W-1:0] count_reg;

    logic             accept;
    logic             full;
    logic             empty;
    logic             append_ok;
    logic             text_ok;
    logic             bad;
    logic             any_tail;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] start_calc;
    logic [EXT_W-1:0] len_ext;
    cell_ctrl_t       ctrl;

    logic [PATTERN_MAX-1:0] wr_en;
    logic [PATTERN_MAX-1:0] hit;
    logic [PATTERN_MAX-1:0] tail_hit;

    assign accept     = item_valid && !item_stall;
    assign item_stall = result_valid_reg && result_stall;

    assign full    = (len_reg == LEN_W'(PATTERN_MAX));
    assign empty   = (len_reg == '0);
    assign pos_inc = pos_reg + POS_W'(1);
    // First byte of an occurrence ending at this text byte.
    assign start_calc = pos_inc - POS_W'(len_reg);
    assign any_tail   = |tail_hit;

    // Command decode.
    always_comb
    begin
        append_ok      = 1'b0;
        text_ok        = 1'b0;
        bad            = 1'b0;
        len_next       = len_reg;
        pos_next       = pos_reg;
        ctrl.shift     = 1'b0;
        ctrl.flush     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.drop      = 1'b0;
        ctrl.data_char = data_char;
        case (func)
            FUNC_CLEAR:
            begin
                ctrl.flush = accept;
                ctrl.drop  = accept;
                len_next   = '0;
                pos_next   = '0;
            end
            FUNC_APPEND:
            begin
                if (full)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    append_ok  = accept;
                    ctrl.flush = accept;
                    ctrl.load  = accept;
                    len_next   = len_reg + LEN_W'(1);
                    pos_next   = '0;
                end
            end
            FUNC_TEXT:
            begin
                if (empty)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    text_ok    = 1'b1;
                    ctrl.shift = accept;
                    pos_next   = pos_inc;
                end
            end
            FUNC_RESTART:
            begin
                ctrl.flush = accept;
                pos_next   = '0;
            end
            default:
            begin
                bad = 1'b0;
            end
        endcase
    end

    assign len_ext = EXT_W'(len_next);

    // Cell row; each cell takes its predecessor's flag, cell 0 always starts one.
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic prev;
        assign wr_en[i] = append_ok && (len_reg == LEN_W'(i));
        if (i == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_body
            assign prev = hit[i-1];
        end

        kmp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_en    (wr_en[i]),
            .prev_hit (prev),
            .hit      (hit[i]),
            .tail_hit (tail_hit[i])
        );
    end

    always_comb
    begin
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                len_reg <= len_next;
                pos_reg <= pos_next;
            end
        end
    end

    // Result payload, loaded on each accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            match_reg <= text_ok && any_tail;
            start_reg <= (text_ok && any_tail) ? start_calc : '0;
            error_reg <= bad;
            count_reg <= len_ext[COUNT_W-1:0];
        end
    end

    assign result_valid  = result_valid_reg;
    assign match         = match_reg;
    assign match_start   = start_reg;
    assign error         = error_reg;
    assign pattern_count = count_reg;

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the streaming KMP byte matcher.
`timescale 1ns / 1ps
module tb_top;
    import kmp_pkg::*;

    localparam int PATTERN_MAX  = 32;
    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_ROWS     = 23;

    typedef struct packed {
        logic               match;
        logic [POS_W-1:0]   start;
        logic               error;
        logic [COUNT_W-1:0] count;
    } kmp_result_t;

    // Directed stimulus row: a command repeated reps times; want is used when typed is set.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] data;
        logic [7:0]        reps;
        logic              typed;
        kmp_result_t       want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  data_char;
    logic               result_valid;
    logic               result_stall;
    logic               match;
    logic [POS_W-1:0]   match_start;
    logic               error;
    logic [COUNT_W-1:0] pattern_count;

    kmp_stream_matcher #(.PATTERN_MAX(PATTERN_MAX)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .func          (func),
        .data_char     (data_char),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .match         (match),
        .match_start   (match_start),
        .error         (error),
        .pattern_count (pattern_count)
    );

    // Shadow of the matcher state
    logic [CHAR_W-1:0] pat_bytes [PATTERN_MAX];
    int                border [PATTERN_MAX];
    int                pat_len;
    int                build_len;
    int                matched_len;
    logic [POS_W-1:0]  text_pos;

    kmp_result_t awaited_results [$];
    int          fail_count;
    int          items_sent;
    int          burst_left;
    int          cycle_count = 0;
    int          stall_mode;
    int          stall_left;
    logic [15:0] stall_mask;

    dir_row_t directed_rows [NUM_ROWS] = '{
        '{FUNC_TEXT,    8'h61, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b1, 6'd0}},  // text, no pattern
        '{FUNC_RESTART, 8'h00, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b0, 6'd0}},
        '{FUNC_APPEND,  8'h00, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'h00, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'hFF, 8'd1,  1'b0, '0},
        '{FUNC_CLEAR,   8'h5A, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b0, 6'd0}},
        '{FUNC_APPEND,  8'h61, 8'd1,  1'b0, '0},
        '{FUNC_APPEND,  8'h62, 8'd1,  1'b0, '0},
        '{FUNC_APPEND,  8'h61, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'h61, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'h62, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'h61, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'h62, 8'd1,  1'b0, '0},
        '{FUNC_TEXT,    8'h61, 8'd1,  1'b0, '0},  // overlapping occurrence
        '{FUNC_RESTART, 8'hC3, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b0, 6'd3}},
        '{FUNC_TEXT,    8'h61, 8'd1,  1'b0, '0},
        '{FUNC_CLEAR,   8'h00, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b0, 6'd0}},
        '{FUNC_APPEND,  8'hFF, 8'd32, 1'b0, '0},
        '{FUNC_APPEND,  8'h00, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b1, 6'd32}}, // pattern full
        '{FUNC_TEXT,    8'hFF, 8'd34, 1'b0, '0},
        '{FUNC_TEXT,    8'h00, 8'd1,  1'b0, '0},
        '{FUNC_RESTART, 8'hFF, 8'd1,  1'b0, '0},
        '{FUNC_CLEAR,   8'hFF, 8'd1,  1'b1, '{1'b0, 32'd0, 1'b0, 6'd0}}
    };

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Advances the shadow state by one command and returns the result it causes.
    function automatic kmp_result_t next_kmp_result(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
        kmp_result_t r;
        int p;
        int m;
        r = '0;
        case (f)
            FUNC_CLEAR:
            begin
                pat_len     = 0;
                build_len   = 0;
                matched_len = 0;
                text_pos    = '0;
            end
            FUNC_APPEND:
            begin
                if (pat_len >= PATTERN_MAX)
                    r.error = 1'b1;
                else
                begin
                    p = 0;
                    if (pat_len > 0)
                    begin
                        p = build_len;
                        while (p > 0 && pat_bytes[p] != c)
                            p = border[p-1];
                        if (pat_bytes[p] == c)
                            p++;
                    end
                    pat_bytes[pat_len] = c;
                    border[pat_len]    = p;
                    build_len          = p;
                    pat_len++;
                    matched_len = 0;
                    text_pos    = '0;
                end
            end
            FUNC_TEXT:
            begin
                if (pat_len == 0)
                    r.error = 1'b1;
                else
                begin
                    m = (matched_len >= pat_len) ? 0 : matched_len;
                    while (m > 0 && pat_bytes[m] != c)
                        m = border[m-1];
                    if (pat_bytes[m] == c)
                        m++;
                    text_pos = text_pos + 1;
                    if (m >= pat_len)
                    begin
                        r.match = 1'b1;
                        r.start = text_pos - POS_W'(pat_len);
                        m = border[pat_len-1];
                    end
                    matched_len = m;
                end
            end
            default:
            begin
                matched_len = 0;
                text_pos    = '0;
            end
        endcase
        r.count = COUNT_W'(pat_len);
        return r;
    endfunction

    // Presents one beat, waits for it to be taken, then records what it should return.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] d,
                             input logic typed, input kmp_result_t want);
        int gap;
        kmp_result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        item_valid <= 1'b1;
        func       <= f;
        data_char  <= d;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
        predicted = next_kmp_result(f, d);
        awaited_results.insert(awaited_results.size(), typed ? want : predicted);
    endtask

    // One session: clear, build a pattern over a small alphabet, then stream text.
    task automatic random_session();
        logic [CHAR_W-1:0] alpha [3];
        logic [CHAR_W-1:0] shadow [$];
        logic [CHAR_W-1:0] ch;
        logic [FUNC_W-1:0] f;
        int n_sym;
        int plen;
        int tlen;
        int pick;
        n_sym = $urandom_range(1, 3);
        foreach (alpha[i])
            alpha[i] = CHAR_W'($urandom_range(0, 255));
        send_item(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
            send_item(FUNC_TEXT, alpha[0], 1'b0, '0);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            plen = $urandom_range(1, 5);
        else if (pick < 90)
            plen = $urandom_range(6, 12);
        else if (pick < 97)
            plen = $urandom_range(13, PATTERN_MAX);
        else
            plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 3);
        for (int i = 0; i < plen; i++)
        begin
            ch = alpha[$urandom_range(0, n_sym - 1)];
            send_item(FUNC_APPEND, ch, 1'b0, '0);
            if (shadow.size() < PATTERN_MAX)
                shadow.insert(shadow.size(), ch);
        end
        tlen = $urandom_range(10, 60);
        for (int i = 0; i < tlen; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && shadow.size() <= 12)
            begin
                foreach (shadow[j])
                    send_item(FUNC_TEXT, shadow[j], 1'b0, '0);
            end
            else if (pick < 28)
                send_item(FUNC_RESTART, CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
            else if (pick < 31)
            begin
                f  = FUNC_W'($urandom_range(0, 3));
                ch = CHAR_W'($urandom_range(0, 255));
                send_item(f, ch, 1'b0, '0);
                if (f == FUNC_CLEAR)
                    shadow.delete();
                else if (f == FUNC_APPEND && shadow.size() < PATTERN_MAX)
                    shadow.insert(shadow.size(), ch);
            end
            else if (pick < 34)
                send_item(FUNC_TEXT, CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
            else
                send_item(FUNC_TEXT, alpha[$urandom_range(0, n_sym - 1)], 1'b0, '0);
        end
    endtask

    // Receiver stall: modes change every so often, including stretches with no stall.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
            stall_mask = 16'($urandom);
        end
        else
            stall_left--;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= stall_mask[cycle_count % 16];
        endcase
    end

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result beats are checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: extra result beat: expected none, actual m=%0d s=%0d e=%0d c=%0d",
                         $time, match, match_start, error, pattern_count);
                fail_count++;
            end
            else
            begin
                check_field("match", POS_W'(awaited_results[0].match), POS_W'(match));
                check_field("match_start", awaited_results[0].start, match_start);
                check_field("error", POS_W'(awaited_results[0].error), POS_W'(error));
                check_field("pattern_count", POS_W'(awaited_results[0].count),
                            POS_W'(pattern_count));
                void'(awaited_results.pop_front());
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** kmp_stream_matcher: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        func         <= FUNC_CLEAR;
        data_char    <= '0;
        result_stall <= 1'b0;
        fail_count   = 0;
        items_sent   = 0;
        burst_left   = 0;
        stall_left   = 0;
        stall_mode   = 0;
        stall_mask   = '0;
        pat_len      = 0;
        build_len    = 0;
        matched_len  = 0;
        text_pos     = '0;
        foreach (pat_bytes[i])
        begin
            pat_bytes[i] = '0;
            border[i]    = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_item(directed_rows[r].func, directed_rows[r].data,
                          directed_rows[r].typed, directed_rows[r].want);

        while (items_sent < RANDOM_ITEMS)
            random_session();

        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** kmp_stream_matcher: PASSED **");
        else
            $display("** kmp_stream_matcher: FAILED **");
        $finish;
    end

endmodule

### kmp_stream_matcher.f
src/kmp_pkg.sv
src/kmp_cell.sv
src/kmp_stream_matcher.sv
test/tb_top.sv
